[rtl/byte_ring_fifo_thresholds_defines.svh]
// Assertion macros for the checker file of the byte ring FIFO.
// Depends on nothing; included by bare file name.
`ifndef BYTE_RING_FIFO_THRESHOLDS_DEFINES_SVH
`define BYTE_RING_FIFO_THRESHOLDS_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define BRFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define BRFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/brft_pkg.sv]
// Shared types, codes and helpers for the byte ring FIFO with threshold events.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package brft_pkg;

    localparam int DEPTH_DEFAULT     = 1024;
    localparam int MAX_BURST_DEFAULT = 64;

    localparam int CNT_W   = 11;
    localparam int LEN_W   = 7;
    localparam int DATA_W  = 8;
    localparam int TOT_W   = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_ENABLE = 3'd4;

    // Result queue between the engine and the output port.
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_LVL_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              last;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  fill_count;
        logic [CNT_W-1:0]  free_count;
        logic [TOT_W-1:0]  write_total;
        logic [TOT_W-1:0]  read_total;
        logic              fill_event;
        logic              space_event;
    } brft_result_t;

    // Free space, zero when the capacity has dropped below the fill.
    function automatic logic [CNT_W-1:0] brft_free(
        input logic [CNT_W-1:0] cap,
        input logic [CNT_W-1:0] held
    );
        brft_free = (cap > held) ? (cap - held) : '0;
    endfunction

endpackage

`default_nettype wire

[rtl/brft_res_fifo.sv]
// Small result queue that decouples the FIFO engine from the output handshake.
// Depends on brft_pkg for the result struct and queue depth.
`default_nettype none

module brft_res_fifo
    import brft_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire brft_result_t         push_data,
    input  wire logic                 pop_ready,
    output logic                      out_valid,
    output brft_result_t              out_data,
    output logic [RES_LVL_W-1:0]      level
);

    brft_result_t         slot_mem [RES_DEPTH];
    logic [RES_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [RES_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RES_LVL_W-1:0] level_reg, level_next;
    logic                 pop_fire;

    assign out_valid = (level_reg != '0);
    assign out_data  = slot_mem[rd_ptr_reg];
    assign level     = level_reg;
    assign pop_fire  = out_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        level_next  = level_reg + RES_LVL_W'(push) - RES_LVL_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/byte_ring_fifo_thresholds.sv]
// Byte ring FIFO with all-or-nothing bursts, counters and threshold events.
// A write byte or a query is taken when the engine is idle and the result queue has room; a write
// burst of N bytes takes N items. A read of N bytes is accepted, then fetched at one byte per
// cycle while the result queue has room, through the single read port of the byte store
// (registered read data), and each fetched byte is then handed to the result queue.
// Results wait in a four-entry queue, so a stalled output does not block input
// until the queue fills. Configuration writes are taken every cycle.
// Depends on brft_pkg and brft_res_fifo.
`default_nettype none

module byte_ring_fifo_thresholds
    import brft_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int MAX_BURST = MAX_BURST_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [LEN_W-1:0]     burst_length,
    input  wire logic [DATA_W-1:0]    data_in,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DATA_W-1:0]         data_out,
    output logic                      last,
    output logic [STAT_W-1:0]         status,
    output logic [CNT_W-1:0]          fill_count,
    output logic [CNT_W-1:0]          free_count,
    output logic [TOT_W-1:0]          write_total,
    output logic [TOT_W-1:0]          read_total,
    output logic                      fill_event,
    output logic                      space_event
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    // Configuration registers
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] fill_thresh_reg;
    logic             fill_en_reg;
    logic [CNT_W-1:0] space_thresh_reg;
    logic             space_en_reg;

    // Engine state
    state_t            state_reg, state_next;
    logic [AW-1:0]     ridx_reg, ridx_next;
    logic [AW-1:0]     widx_reg, widx_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [TOT_W-1:0]  wtot_reg, wtot_next;
    logic [TOT_W-1:0]  rtot_reg, rtot_next;
    logic [LEN_W-1:0]  burst_left_reg, burst_left_next;
    logic              burst_acc_reg, burst_acc_next;
    logic [LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic              sev_reg, sev_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;

    logic [DATA_W-1:0] byte_store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Combinational
    logic [CNT_W-1:0]  cap_eff;
    logic [LEN_W-1:0]  len_eff;
    logic [CNT_W-1:0]  free_now;
    logic              in_fire;
    logic              is_write;
    logic              first_byte;
    logic [LEN_W-1:0]  left_cur;
    logic              acc_cur;
    logic              do_store;
    logic [LEN_W-1:0]  left_after;
    logic [CNT_W-1:0]  held_w;
    logic [TOT_W-1:0]  wtot_w;
    logic [CNT_W-1:0]  held_rd;
    logic              underflow;
    logic              issue;
    logic              res_push;
    brft_result_t      res_data;
    brft_result_t      q_data;
    logic              q_valid;
    logic [RES_LVL_W-1:0] q_level;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                              input logic [CNT_W-1:0] cap);
        logic [31:0] nxt;
        nxt = 32'(idx) + 32'd1;
        advance = (nxt >= 32'(cap)) ? '0 : AW'(nxt);
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CNT_W'(1);
        else if (32'(cap_reg) > DEPTH)
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = cap_reg;

        if (burst_length == '0)
            len_eff = LEN_W'(1);
        else if (32'(burst_length) > MAX_BURST)
            len_eff = LEN_W'(MAX_BURST);
        else
            len_eff = burst_length;
    end

    assign free_now = brft_free(cap_eff, held_reg);
    assign in_ready = (state_reg == ST_IDLE) && !pend_reg && (q_level < RES_LVL_W'(RES_DEPTH));
    assign in_fire  = in_valid && in_ready;
    assign is_write = in_fire && (op == OP_WRITE);

    // Write burst: the first byte decides for the whole burst.
    assign first_byte = (burst_left_reg == '0);
    assign left_cur   = first_byte ? len_eff : burst_left_reg;
    assign acc_cur    = first_byte ? (free_now >= CNT_W'(len_eff)) : burst_acc_reg;
    assign do_store   = is_write && acc_cur && (held_reg < cap_eff);
    assign left_after = left_cur - 1'b1;
    assign held_w     = held_reg + CNT_W'(do_store);
    assign wtot_w     = wtot_reg + TOT_W'(do_store);

    assign underflow = held_reg < CNT_W'(len_eff);
    assign held_rd   = held_reg - CNT_W'(len_eff);

    // Issue a store read only when the queue can take its result.
    assign issue = (state_reg == ST_READ) &&
                   ((q_level + RES_LVL_W'(pend_reg)) < RES_LVL_W'(RES_DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        ridx_next       = ridx_reg;
        widx_next       = widx_reg;
        held_next       = held_reg;
        wtot_next       = wtot_reg;
        rtot_next       = rtot_reg;
        burst_left_next = burst_left_reg;
        burst_acc_next  = burst_acc_reg;
        rd_left_next    = rd_left_reg;
        sev_next        = sev_reg;
        pend_next       = 1'b0;
        pend_last_next  = pend_last_reg;
        res_push        = 1'b0;

        res_data             = '0;
        res_data.last        = 1'b1;
        res_data.status      = STAT_OK;
        res_data.fill_count  = held_reg;
        res_data.free_count  = free_now;
        res_data.write_total = wtot_reg;
        res_data.read_total  = rtot_reg;

        // Byte fetched last cycle goes to the queue now.
        if (pend_reg)
        begin
            res_push             = 1'b1;
            res_data.data_out    = rd_data_reg;
            res_data.last        = pend_last_reg;
            res_data.space_event = pend_last_reg && sev_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        OP_WRITE:
                        begin
                            held_next       = held_w;
                            wtot_next       = wtot_w;
                            burst_left_next = left_after;
                            burst_acc_next  = (left_after == '0) ? 1'b0 : do_store;
                            if (do_store)
                                widx_next = advance(widx_reg, cap_eff);
                            if (left_after == '0)
                            begin
                                res_push             = 1'b1;
                                res_data.status      = do_store ? STAT_OK : STAT_OVERFLOW;
                                res_data.fill_count  = held_w;
                                res_data.free_count  = brft_free(cap_eff, held_w);
                                res_data.write_total = wtot_w;
                                res_data.fill_event  = do_store && fill_en_reg &&
                                                       (held_w >= fill_thresh_reg);
                            end
                        end
                        OP_READ:
                        begin
                            if (underflow)
                            begin
                                res_push        = 1'b1;
                                res_data.status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                held_next    = held_rd;
                                rtot_next    = rtot_reg + TOT_W'(len_eff);
                                rd_left_next = len_eff;
                                sev_next     = space_en_reg &&
                                    (brft_free(cap_eff, held_rd) >= space_thresh_reg);
                                state_next   = ST_READ;
                            end
                        end
                        OP_QUERY:
                        begin
                            res_push = 1'b1;
                        end
                        default:
                        begin
                            // unused op: drop
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (issue)
                begin
                    ridx_next      = advance(ridx_reg, cap_eff);
                    rd_left_next   = rd_left_reg - 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (rd_left_reg == LEN_W'(1));
                    if (rd_left_reg == LEN_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg          <= CAP_RESET;
            fill_thresh_reg  <= '0;
            fill_en_reg      <= 1'b0;
            space_thresh_reg <= '0;
            space_en_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAPACITY:     cap_reg          <= cfg_data;
                CFG_FILL_THRESH:  fill_thresh_reg  <= cfg_data;
                CFG_FILL_ENABLE:  fill_en_reg      <= cfg_data[0];
                CFG_SPACE_THRESH: space_thresh_reg <= cfg_data;
                CFG_SPACE_ENABLE: space_en_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ridx_reg       <= '0;
            widx_reg       <= '0;
            held_reg       <= '0;
            wtot_reg       <= '0;
            rtot_reg       <= '0;
            burst_left_reg <= '0;
            burst_acc_reg  <= 1'b0;
            rd_left_reg    <= '0;
            sev_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ridx_reg       <= ridx_next;
            widx_reg       <= widx_next;
            held_reg       <= held_next;
            wtot_reg       <= wtot_next;
            rtot_reg       <= rtot_next;
            burst_left_reg <= burst_left_next;
            burst_acc_reg  <= burst_acc_next;
            rd_left_reg    <= rd_left_next;
            sev_reg        <= sev_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
        end
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_store)
        begin
            byte_store_mem[widx_reg] <= data_in;
        end
        if (issue)
        begin
            rd_data_reg <= byte_store_mem[ridx_reg];
        end
    end

    brft_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop_ready (out_ready),
        .out_valid (q_valid),
        .out_data  (q_data),
        .level     (q_level)
    );

    assign out_valid   = q_valid;
    assign data_out    = q_data.data_out;
    assign last        = q_data.last;
    assign status      = q_data.status;
    assign fill_count  = q_data.fill_count;
    assign free_count  = q_data.free_count;
    assign write_total = q_data.write_total;
    assign read_total  = q_data.read_total;
    assign fill_event  = q_data.fill_event;
    assign space_event = q_data.space_event;

endmodule

`default_nettype wire

[rtl/brft_checker.sv]
// Port-level checks for the byte ring FIFO, bound to the top level.
// Depends on brft_pkg and the assertion macros header.
`default_nettype none
`include "byte_ring_fifo_thresholds_defines.svh"

module brft_checker
    import brft_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DATA_W-1:0] data_out,
    input wire logic              last,
    input wire logic [STAT_W-1:0] status,
    input wire logic              fill_event,
    input wire logic              space_event
);

    // A refused transaction carries one status result and no byte or event.
    `BRFT_ASSERT_NOW(a_refused_shape, clk, rst_n, out_valid && (status != STAT_OK), last && (data_out == '0) && !fill_event && !space_event, "refused result malformed")

    // Events only close a successful operation.
    `BRFT_ASSERT_NOW(a_event_on_last, clk, rst_n, out_valid && (fill_event || space_event), last && (status == STAT_OK) && !(fill_event && space_event), "event on wrong result")

    // Hold a stalled result.
    `BRFT_ASSERT_NXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    `BRFT_ASSERT_NXT(a_hold_payload, clk, rst_n, out_valid && !out_ready, $stable(data_out) && $stable(status) && $stable(last), "stalled result changed")

endmodule

bind byte_ring_fifo_thresholds brft_checker u_brft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_out    (data_out),
    .last        (last),
    .status      (status),
    .fill_event  (fill_event),
    .space_event (space_event)
);

`default_nettype wire
